/* rtl/core/otq_pkg.sv */
// otq_pkg: shared types and constants for the ordered timer queue.
// Used by otq_ctrl, otq_dpath and ordered_timer_queue. No dependencies.
`default_nettype none

package otq_pkg;

    localparam int unsigned MAX_RESULTS  = 32;
    localparam int unsigned FIELD_TIME_W = 56;
    localparam int unsigned ID_W         = 32;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic fire;
        logic emit_add;
        logic emit_cancel;
        logic emit_quiet;
        logic emit_start;
        logic buf_rd;
        logic emit_tick;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic fire_ok;
        logic cnt_zero;
        logic emit_last;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/core/otq_ctrl.sv */
// otq_ctrl: request sequencer for the ordered timer queue.
// Depends on otq_pkg; drives the command struct of otq_dpath.
`default_nettype none

module otq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [1:0]    i_opcode,
    input  wire otq_pkg::t_stat i_stat,
    output otq_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_op, n_op;
    otq_pkg::t_cmd w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && (i_opcode == otq_pkg::OP_ADD || i_opcode == otq_pkg::OP_CANCEL
                                || i_opcode == otq_pkg::OP_TICK)) begin
                    w_cmd.load       = 1'b1;
                    w_cmd.scan_start = 1'b1;
                    n_op             = i_opcode;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_stat.scan_done) begin
                    w_cmd.scan_step = 1'b1;
                end else begin
                    unique case (r_op)
                        otq_pkg::OP_ADD: begin
                            w_cmd.emit_add = 1'b1;
                            n_state        = S_IDLE;
                        end
                        otq_pkg::OP_CANCEL: begin
                            w_cmd.emit_cancel = 1'b1;
                            n_state           = S_IDLE;
                        end
                        default: begin
                            priority if (i_stat.fire_ok) begin
                                w_cmd.fire       = 1'b1;
                                w_cmd.scan_start = 1'b1;
                            end else if (i_stat.cnt_zero) begin
                                w_cmd.emit_quiet = 1'b1;
                                n_state          = S_IDLE;
                            end else begin
                                w_cmd.emit_start = 1'b1;
                                n_state          = S_EMIT_RD;
                            end
                        end
                    endcase
                end
            end
            S_EMIT_RD: begin
                w_cmd.buf_rd = 1'b1;
                n_state      = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                w_cmd.emit_tick = 1'b1;
                n_state         = i_stat.emit_last ? S_IDLE : S_EMIT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= otq_pkg::OP_ADD;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* rtl/core/otq_dpath.sv */
// otq_dpath: timer table, scan accumulators, fired-id buffer and result registers.
// Depends on otq_pkg; sequenced by otq_ctrl.
`default_nettype none

module otq_dpath #(
    parameter int unsigned NUM_TIMERS = 32,
    parameter int unsigned TIME_BITS  = 56
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire otq_pkg::t_cmd                     i_cmd,
    output otq_pkg::t_stat                         o_stat,
    input  wire logic [1:0]                        i_opcode,
    input  wire logic [otq_pkg::FIELD_TIME_W-1:0]  i_deadline,
    input  wire logic [otq_pkg::FIELD_TIME_W-1:0]  i_repeat_interval,
    input  wire logic [otq_pkg::ID_W-1:0]          i_cancel_id,
    input  wire logic [otq_pkg::FIELD_TIME_W-1:0]  i_now_time,
    output logic                                   o_valid,
    output logic [1:0]                             o_kind,
    output logic [1:0]                             o_status,
    output logic [otq_pkg::ID_W-1:0]               o_timer_id,
    output logic                                   o_fired,
    output logic                                   o_earliest_changed,
    output logic [otq_pkg::FIELD_TIME_W-1:0]       o_next_deadline,
    output logic                                   o_next_valid,
    output logic                                   o_last
);

    localparam int unsigned IW = $clog2(NUM_TIMERS);
    localparam int unsigned CW = $clog2(otq_pkg::MAX_RESULTS + 1);
    localparam int unsigned BW = $clog2(otq_pkg::MAX_RESULTS);
    localparam int unsigned TW = TIME_BITS;
    localparam int unsigned DW = otq_pkg::ID_W;

    logic [1:0]    r_opc;
    logic [TW-1:0] r_when, r_ivl, r_now;
    logic [DW-1:0] r_want;

    logic [TW-1:0] m_dl [NUM_TIMERS];
    logic [TW-1:0] m_iv [NUM_TIMERS];
    logic [DW-1:0] m_id [NUM_TIMERS];
    logic [TW-1:0] r_rd_dl, r_rd_iv;
    logic [DW-1:0] r_rd_id;

    logic [NUM_TIMERS-1:0] r_valid, r_done;

    logic [IW:0]   r_idx;
    logic          r_pv;
    logic [IW-1:0] r_pidx;

    logic          r_any, r_ff, r_mf, r_bf;
    logic [TW-1:0] r_min, r_bdl, r_biv;
    logic [IW-1:0] r_fi, r_mi, r_bi;
    logic [DW-1:0] r_bid;

    logic [DW-1:0] r_nid;
    logic [CW-1:0] r_cnt, r_eidx;
    logic [DW-1:0] m_buf [otq_pkg::MAX_RESULTS];
    logic [DW-1:0] r_buf_q;

    logic          r_o_valid, r_o_fired, r_o_chg, r_o_nv, r_o_last;
    logic [1:0]    r_o_kind, r_o_status;
    logic [DW-1:0] r_o_id;
    logic [TW-1:0] r_o_nd;

    logic          w_v, w_match, w_due, w_better, w_min_upd, w_free;
    logic          w_rd_en, w_chg;
    logic [TW:0]   w_sum;
    logic [TW-1:0] w_rearm, w_keep_nd;
    logic [63:0]   w_nd64;

    assign w_v       = r_pv && r_valid[r_pidx];
    assign w_match   = w_v && (r_opc == otq_pkg::OP_CANCEL) && !r_mf && (r_rd_id == r_want);
    assign w_due     = w_v && !r_done[r_pidx] && (r_rd_dl <= r_now);
    assign w_better  = w_due && (!r_bf || (r_rd_dl < r_bdl)
                                || ((r_rd_dl == r_bdl) && (r_rd_id < r_bid)));
    assign w_min_upd = w_v && !w_match && (!r_any || (r_rd_dl < r_min));
    assign w_free    = r_pv && !r_valid[r_pidx] && !r_ff;
    assign w_rd_en   = i_cmd.scan_step && (r_idx < (IW+1)'(NUM_TIMERS));

    assign w_sum     = {1'b0, r_now} + {1'b0, r_biv};
    assign w_rearm   = w_sum[TW] ? {TW{1'b1}} : w_sum[TW-1:0];
    assign w_chg     = !r_any || (r_when < r_min);
    assign w_keep_nd = r_any ? r_min : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_done    <= '0;
            r_idx     <= '0;
            r_pv      <= 1'b0;
            r_any     <= 1'b0;
            r_ff      <= 1'b0;
            r_mf      <= 1'b0;
            r_bf      <= 1'b0;
            r_nid     <= DW'(1);
            r_cnt     <= '0;
            r_eidx    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_done <= '0;
                r_cnt  <= '0;
            end
            if (i_cmd.scan_start) begin
                r_idx <= '0;
                r_pv  <= 1'b0;
                r_any <= 1'b0;
                r_ff  <= 1'b0;
                r_mf  <= 1'b0;
                r_bf  <= 1'b0;
            end else begin
                if (w_rd_en) begin
                    r_idx <= r_idx + (IW+1)'(1);
                end
                r_pv <= w_rd_en;
                if (w_min_upd) r_any <= 1'b1;
                if (w_free)    r_ff  <= 1'b1;
                if (w_match)   r_mf  <= 1'b1;
                if (w_better)  r_bf  <= 1'b1;
            end
            if (i_cmd.emit_add && r_ff) begin
                r_valid[r_fi] <= 1'b1;
                r_nid         <= r_nid + DW'(1);
            end
            if (i_cmd.emit_cancel && r_mf) begin
                r_valid[r_mi] <= 1'b0;
            end
            if (i_cmd.fire) begin
                r_done[r_bi] <= 1'b1;
                r_cnt        <= r_cnt + CW'(1);
                if (r_biv == '0) begin
                    r_valid[r_bi] <= 1'b0;
                end
            end
            if (i_cmd.emit_start) begin
                r_eidx <= '0;
            end else if (i_cmd.emit_tick) begin
                r_eidx <= r_eidx + CW'(1);
            end
            r_o_valid <= i_cmd.emit_add || i_cmd.emit_cancel || i_cmd.emit_quiet
                         || i_cmd.emit_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opc  <= i_opcode;
            r_when <= TW'(i_deadline);
            r_ivl  <= TW'(i_repeat_interval);
            r_want <= i_cancel_id;
            r_now  <= TW'(i_now_time);
        end
        if (!i_cmd.scan_start) begin
            if (w_min_upd) r_min <= r_rd_dl;
            if (w_free)    r_fi  <= r_pidx;
            if (w_match)   r_mi  <= r_pidx;
            if (w_better) begin
                r_bi  <= r_pidx;
                r_bdl <= r_rd_dl;
                r_bid <= r_rd_id;
                r_biv <= r_rd_iv;
            end
        end
        if (w_rd_en) begin
            r_pidx <= r_idx[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_add && r_ff) begin
            m_dl[r_fi] <= r_when;
            m_iv[r_fi] <= r_ivl;
            m_id[r_fi] <= r_nid;
        end else if (i_cmd.fire && (r_biv != '0)) begin
            m_dl[r_bi] <= w_rearm;
        end
        if (w_rd_en) begin
            r_rd_dl <= m_dl[r_idx[IW-1:0]];
            r_rd_iv <= m_iv[r_idx[IW-1:0]];
            r_rd_id <= m_id[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fire) begin
            m_buf[r_cnt[BW-1:0]] <= r_bid;
        end
        if (i_cmd.buf_rd) begin
            r_buf_q <= m_buf[r_eidx[BW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.emit_add) begin
            r_o_kind  <= otq_pkg::KIND_ADD;
            r_o_fired <= 1'b0;
            r_o_last  <= 1'b1;
            if (r_ff) begin
                r_o_status <= otq_pkg::ST_OK;
                r_o_id     <= r_nid;
                r_o_chg    <= w_chg;
                r_o_nd     <= w_chg ? r_when : r_min;
                r_o_nv     <= 1'b1;
            end else begin
                r_o_status <= otq_pkg::ST_FULL;
                r_o_id     <= '0;
                r_o_chg    <= 1'b0;
                r_o_nd     <= w_keep_nd;
                r_o_nv     <= r_any;
            end
        end else if (i_cmd.emit_cancel) begin
            r_o_kind   <= otq_pkg::KIND_CANCEL;
            r_o_status <= r_mf ? otq_pkg::ST_OK : otq_pkg::ST_NOT_FOUND;
            r_o_id     <= r_want;
            r_o_fired  <= 1'b0;
            r_o_chg    <= 1'b0;
            r_o_nd     <= w_keep_nd;
            r_o_nv     <= r_any;
            r_o_last   <= 1'b1;
        end else if (i_cmd.emit_quiet || i_cmd.emit_tick) begin
            r_o_kind   <= otq_pkg::KIND_TICK;
            r_o_status <= otq_pkg::ST_OK;
            r_o_id     <= i_cmd.emit_tick ? r_buf_q : '0;
            r_o_fired  <= i_cmd.emit_tick;
            r_o_chg    <= 1'b0;
            r_o_nd     <= w_keep_nd;
            r_o_nv     <= r_any;
            r_o_last   <= i_cmd.emit_quiet || o_stat.emit_last;
        end
    end

    assign o_stat.scan_done = (r_idx == (IW+1)'(NUM_TIMERS)) && !r_pv;
    assign o_stat.fire_ok   = r_bf && (r_cnt < CW'(otq_pkg::MAX_RESULTS));
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.emit_last = (r_eidx == (r_cnt - CW'(1)));

    assign w_nd64             = 64'(r_o_nd);
    assign o_valid            = r_o_valid;
    assign o_kind             = r_o_kind;
    assign o_status           = r_o_status;
    assign o_timer_id         = r_o_id;
    assign o_fired            = r_o_fired;
    assign o_earliest_changed = r_o_chg;
    assign o_next_deadline    = w_nd64[otq_pkg::FIELD_TIME_W-1:0];
    assign o_next_valid       = r_o_nv;
    assign o_last             = r_o_last;

endmodule

`default_nettype wire

/* rtl/core/ordered_timer_queue.sv */
// ordered_timer_queue: top level of the timer table with ordered expiry.
// Depends on otq_pkg, otq_ctrl and otq_dpath.
//
// Usage: raise start with i_opcode and its operands while busy is low; the
// request is taken at that edge and busy stays high until its last result.
// Opcode 0 arms a timer, 1 cancels by id, 2 ticks at i_now_time; opcode 3 is
// not taken and gives no result. Results appear for one cycle each, marked
// by o_valid, with o_last on the final one; the receiver cannot stall them.
// Each table scan reads one slot per cycle from the slot memory. Add and
// cancel take one scan each to their single result. A tick firing k timers
// runs k+1 scans, then gives its results from the fired-id buffer, reading
// each id from the buffer before it is output; a quiet tick gives one result
// after one scan. At most 32 timers fire per tick. Every result carries the
// earliest armed deadline after the whole request. Reset clears all slot
// valid bits and sets the next id to one; slot contents are not cleared.
`default_nettype none

module ordered_timer_queue #(
    parameter int unsigned NUM_TIMERS = 32,
    parameter int unsigned TIME_BITS  = 56
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       i_opcode,
    input  wire logic [otq_pkg::FIELD_TIME_W-1:0] i_deadline,
    input  wire logic [otq_pkg::FIELD_TIME_W-1:0] i_repeat_interval,
    input  wire logic [otq_pkg::ID_W-1:0]         i_cancel_id,
    input  wire logic [otq_pkg::FIELD_TIME_W-1:0] i_now_time,
    output logic                                  o_valid,
    output logic [1:0]                            o_kind,
    output logic [1:0]                            o_status,
    output logic [otq_pkg::ID_W-1:0]              o_timer_id,
    output logic                                  o_fired,
    output logic                                  o_earliest_changed,
    output logic [otq_pkg::FIELD_TIME_W-1:0]      o_next_deadline,
    output logic                                  o_next_valid,
    output logic                                  o_last
);

    otq_pkg::t_cmd  w_cmd;
    otq_pkg::t_stat w_stat;

    otq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    otq_dpath #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_opcode           (i_opcode),
        .i_deadline         (i_deadline),
        .i_repeat_interval  (i_repeat_interval),
        .i_cancel_id        (i_cancel_id),
        .i_now_time         (i_now_time),
        .o_valid            (o_valid),
        .o_kind             (o_kind),
        .o_status           (o_status),
        .o_timer_id         (o_timer_id),
        .o_fired            (o_fired),
        .o_earliest_changed (o_earliest_changed),
        .o_next_deadline    (o_next_deadline),
        .o_next_valid       (o_next_valid),
        .o_last             (o_last)
    );

endmodule

`default_nettype wire
